// ===== design/amf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf_pkg
// Shared types and sizes for the array mode finder: store depth, index and
// fill widths, and the packed item and result types.
// ----------------------------------------------------------------------------
package amf_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int FILL_W       = $clog2(MAX_ELEMENTS + 1);
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 7;

  typedef struct packed {
    logic signed [VAL_W-1:0] data_value;
    logic                    last_item;
  } amf_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] mode_value;
    logic [CNT_W-1:0]        mode_count;
    logic                    last_mode;
    logic                    overflow_seen;
  } amf_out_t;

endpackage

// ===== design/amf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amf_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module amf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/array_mode_finder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_mode_finder_core
// Finds every most-frequent value of a loaded set and reports them in
// ascending signed order.
//
// Input: an item is taken at a rising edge with start high and busy low.
// Each item writes one element into the value RAM; an element that
// arrives with the store full is dropped and the run is flagged.
// An item with last_item set raises busy and starts the search.
// Count pass: for each of the N stored elements, a fetch state, a latch
// state, a sweep of the value RAM and a write of its count into the count
// RAM; a repeat of an earlier element writes zero.
// Emit pass: per mode, a sweep over both RAMs picks the next larger mode,
// then the emit flag latches it into result and raises valid with it.
// Results: valid is high for exactly one cycle per result; the receiver
// takes it in that cycle and cannot stall. busy is low again in the cycle
// of the last result, so the next set may load at the edge that ends it.
// Reset: empties the store, clears the overflow flag, returns to idle.
// ----------------------------------------------------------------------------
module array_mode_finder_core
  import amf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  amf_in_t  item,
  output logic     valid,
  output amf_out_t result
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_LATCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_WRCNT = 6'b010000,
    S_ESCAN = 6'b100000
  } state_t;

  state_t state;
  logic   emit;

  logic [FILL_W-1:0] fill_count;
  logic              overflow_flag;
  logic [FILL_W-1:0] i_cnt;
  logic [FILL_W-1:0] j_cnt;
  logic              pv;
  logic [IDX_W-1:0]  pj;

  logic [VAL_W-1:0]  vi;
  logic [CNT_W-1:0]  c;
  logic              first;
  logic [CNT_W-1:0]  best;

  logic signed [VAL_W-1:0] minv;
  logic signed [VAL_W-1:0] prev;
  logic                    have_prev;
  logic                    found;
  logic [CNT_W-1:0]        gcount;

  logic              accept;
  logic              val_we;
  logic [IDX_W-1:0]  val_raddr;
  logic [VAL_W-1:0]  val_rdata;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wdata;
  logic [CNT_W-1:0]  cnt_rdata;
  logic              issuing;
  logic              scan_end;
  logic              eq;
  logic              cand;
  logic              new_min;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign val_we  = accept && (fill_count < FILL_W'(MAX_ELEMENTS));
  assign issuing = (j_cnt < fill_count);
  assign scan_end = pv && ({1'b0, pj} == fill_count - FILL_W'(1));

  always_comb begin
    if (state == S_FETCH) begin
      val_raddr = i_cnt[IDX_W-1:0];
    end else begin
      val_raddr = j_cnt[IDX_W-1:0];
    end
  end

  assign cnt_we    = (state == S_WRCNT);
  assign cnt_wdata = first ? c : '0;

  assign eq      = (val_rdata == vi);
  assign cand    = (cnt_rdata == best) &&
                   (!have_prev || ($signed(val_rdata) > prev));
  assign new_min = !found || ($signed(val_rdata) < minv);

  amf_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMENTS)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (fill_count[IDX_W-1:0]),
    .wdata (item.data_value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  amf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ELEMENTS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (i_cnt[IDX_W-1:0]),
    .wdata (cnt_wdata),
    .raddr (j_cnt[IDX_W-1:0]),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      emit          <= 1'b0;
      fill_count    <= '0;
      overflow_flag <= 1'b0;
      pv            <= 1'b0;
    end else begin
      pv <= ((state == S_SCAN) || (state == S_ESCAN)) && issuing;
      pj <= j_cnt[IDX_W-1:0];
      if ((state == S_SCAN) || (state == S_ESCAN)) begin
        if (issuing) begin
          j_cnt <= j_cnt + FILL_W'(1);
        end
      end
      emit <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (val_we) begin
              fill_count <= fill_count + FILL_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (item.last_item) begin
              i_cnt <= '0;
              best  <= '0;
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          vi    <= val_rdata;
          j_cnt <= '0;
          c     <= '0;
          first <= 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (pv && eq) begin
            c <= c + CNT_W'(1);
            if ({1'b0, pj} < i_cnt) begin
              first <= 1'b0;
            end
          end
          if (scan_end) begin
            state <= S_WRCNT;
          end
        end
        S_WRCNT: begin
          if (first && (c > best)) begin
            best <= c;
          end
          i_cnt <= i_cnt + FILL_W'(1);
          j_cnt <= '0;
          if (i_cnt + FILL_W'(1) == fill_count) begin
            have_prev <= 1'b0;
            found     <= 1'b0;
            gcount    <= '0;
            state     <= S_ESCAN;
          end else begin
            state <= S_FETCH;
          end
        end
        S_ESCAN: begin
          if (pv && cand) begin
            gcount <= gcount + CNT_W'(1);
            if (new_min) begin
              minv  <= $signed(val_rdata);
              found <= 1'b1;
            end
          end
          if (scan_end) begin
            emit <= 1'b1;
          end
          if (emit) begin
            result.mode_value    <= minv;
            result.mode_count    <= best;
            result.last_mode     <= (gcount == CNT_W'(1));
            result.overflow_seen <= overflow_flag;
            prev      <= minv;
            have_prev <= 1'b1;
            found     <= 1'b0;
            gcount    <= '0;
            j_cnt     <= '0;
            if (gcount == CNT_W'(1)) begin
              fill_count    <= '0;
              overflow_flag <= 1'b0;
              state         <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= emit;
    end
  end

endmodule
